// ===== src/box_downsample_2x2_merge_assert.svh =====
// Assertion macros shared by the downsample block.
`ifndef BOX_DOWNSAMPLE_2X2_MERGE_ASSERT_SVH
`define BOX_DOWNSAMPLE_2X2_MERGE_ASSERT_SVH

// The property must hold in the same cycle as the condition.
`define BDM_ASSERT_NOW(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("downsample assertion failed");

// The property must hold in the cycle after the condition.
`define BDM_ASSERT_NEXT(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("downsample assertion failed");

`endif

// ===== src/bdm_pkg.sv =====
`default_nettype none

package bdm_pkg;

  localparam int MaxWidth    = 1024;
  localparam int MaxHeight   = 1024;
  localparam int SampleBits  = 32;
  localparam int LineDepth   = MaxWidth / 2;
  localparam int LineIdxBits = $clog2(LineDepth);
  localparam int DimBits     = 11;
  localparam int CoordBits   = 10;
  localparam int DataBits    = 32;
  localparam int AddrBits    = 4;
  localparam int QuadBits    = 2;

  // Decoded sample, pair sum, block sum.
  localparam int MeanBits = SampleBits + 1;
  localparam int PairBits = SampleBits + 2;
  localparam int SumBits  = SampleBits + 3;

  // Register indexes, taken from paddr[3:2].
  localparam logic [1:0] RegTileWidth     = 2'd0;
  localparam logic [1:0] RegTileHeight    = 2'd1;
  localparam logic [1:0] RegSignedSamples = 2'd2;

  localparam logic [DimBits-1:0] WidthReset  = DimBits'(256);
  localparam logic [DimBits-1:0] HeightReset = DimBits'(256);

  typedef logic [PairBits-1:0] pair_t;

  typedef struct packed {
    logic [DimBits-1:0]     w_eff;
    logic [DimBits-1:0]     h_eff;
    logic                   is_signed;
    logic [LineIdxBits-1:0] inject_pos;
    logic                   restart;
  } cfg_t;

  function automatic logic [DimBits-1:0] clamp_even(input logic [DimBits-1:0] v,
                                                    input logic [DimBits-1:0] hi);
    logic [DimBits-1:0] c;
    c = v;
    if (c < DimBits'(2)) c = DimBits'(2);
    if (c > hi) c = hi;
    return {c[DimBits-1:1], 1'b0};
  endfunction

endpackage

`default_nettype wire

// ===== src/bdm_in_if.sv =====
`default_nettype none

interface bdm_in_if;
  logic                            valid;
  logic                            ready;
  logic [bdm_pkg::QuadBits-1:0]    quadrant;
  logic [bdm_pkg::DataBits-1:0]    sample;

  modport source (output valid, quadrant, sample, input ready);
  modport sink (input valid, quadrant, sample, output ready);
endinterface

`default_nettype wire

// ===== src/bdm_out_if.sv =====
`default_nettype none

interface bdm_out_if;
  logic                            valid;
  logic                            ready;
  logic [bdm_pkg::CoordBits-1:0]   out_x;
  logic [bdm_pkg::CoordBits-1:0]   out_y;
  logic [bdm_pkg::DataBits-1:0]    average;
  logic                            tile_done;

  modport source (output valid, out_x, out_y, average, tile_done, input ready);
  modport sink (input valid, out_x, out_y, average, tile_done, output ready);
endinterface

`default_nettype wire

// ===== src/bdm_cell.sv =====
`default_nettype none

// One stage of the line delay: takes its neighbor's pair sum on each push,
// or the new pair sum when it is the entry point of the line.
module bdm_cell (
  input  wire logic           clk,
  input  wire logic           shift,
  input  wire logic           load,
  input  wire bdm_pkg::pair_t load_data,
  input  wire bdm_pkg::pair_t prev_data,
  output bdm_pkg::pair_t      data
);

  always_ff @(posedge clk) begin
    if (shift) begin
      data <= load ? load_data : prev_data;
    end
  end

endmodule

`default_nettype wire

// ===== src/bdm_line_chain.sv =====
`default_nettype none

// Line delay of half a tile width in pair sums. A new pair enters at the
// cell that lies half a width before the tail, so it reaches the tail just
// as the matching pair of the next row arrives.
module bdm_line_chain (
  input  wire logic                                clk,
  input  wire logic                                shift,
  input  wire logic [bdm_pkg::LineIdxBits-1:0]     inject_pos,
  input  wire bdm_pkg::pair_t                      push_data,
  output bdm_pkg::pair_t                           tail_data
);

  bdm_pkg::pair_t cell_data [bdm_pkg::LineDepth];

  for (genvar i = 0; i < bdm_pkg::LineDepth; i++) begin : g_cell
    bdm_pkg::pair_t prev;
    logic           load;

    if (i == 0) begin : g_head
      assign prev = push_data;
    end else begin : g_body
      assign prev = cell_data[i-1];
    end

    assign load = (inject_pos == bdm_pkg::LineIdxBits'(i));

    bdm_cell u_cell (
      .clk       (clk),
      .shift     (shift),
      .load      (load),
      .load_data (push_data),
      .prev_data (prev),
      .data      (cell_data[i])
    );
  end

  assign tail_data = cell_data[bdm_pkg::LineDepth-1];

endmodule

`default_nettype wire

// ===== src/bdm_cfg.sv =====
`default_nettype none

module bdm_cfg (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [bdm_pkg::AddrBits-1:0]    paddr,
  input  wire logic [bdm_pkg::DataBits-1:0]    pwdata,
  output logic      [bdm_pkg::DataBits-1:0]    prdata,
  output logic                                 pready,
  output bdm_pkg::cfg_t                        cfg
);

  logic [bdm_pkg::DimBits-1:0]   tile_width;
  logic [bdm_pkg::DimBits-1:0]   tile_height;
  logic                          signed_samples;
  logic [1:0]                    reg_idx;
  logic                          wr;
  logic [bdm_pkg::DimBits-2:0]   inject_full;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr      = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      tile_width     <= bdm_pkg::WidthReset;
      tile_height    <= bdm_pkg::HeightReset;
      signed_samples <= 1'b0;
    end else if (wr) begin
      unique case (reg_idx)
        bdm_pkg::RegTileWidth:     tile_width     <= pwdata[bdm_pkg::DimBits-1:0];
        bdm_pkg::RegTileHeight:    tile_height    <= pwdata[bdm_pkg::DimBits-1:0];
        bdm_pkg::RegSignedSamples: signed_samples <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      bdm_pkg::RegTileWidth:     prdata = bdm_pkg::DataBits'(tile_width);
      bdm_pkg::RegTileHeight:    prdata = bdm_pkg::DataBits'(tile_height);
      bdm_pkg::RegSignedSamples: prdata = bdm_pkg::DataBits'(signed_samples);
      default:                   prdata = '0;
    endcase
  end

  assign cfg.w_eff = bdm_pkg::clamp_even(tile_width, bdm_pkg::DimBits'(bdm_pkg::MaxWidth));
  assign cfg.h_eff = bdm_pkg::clamp_even(tile_height, bdm_pkg::DimBits'(bdm_pkg::MaxHeight));
  assign cfg.is_signed = signed_samples;

  // Entry cell of the line delay: half a width before the tail.
  assign inject_full    = (bdm_pkg::DimBits-1)'(bdm_pkg::LineDepth)
                          - cfg.w_eff[bdm_pkg::DimBits-1:1];
  assign cfg.inject_pos = inject_full[bdm_pkg::LineIdxBits-1:0];

  // Any write to a known register starts the tile over.
  assign cfg.restart = wr && (reg_idx == bdm_pkg::RegTileWidth
                              || reg_idx == bdm_pkg::RegTileHeight
                              || reg_idx == bdm_pkg::RegSignedSamples);

endmodule

`default_nettype wire

// ===== src/box_downsample_2x2_merge.sv =====
// Each result passes the mid and output registers after its 2x2 block's last item.
// Throughput: one item per cycle unless results stall; the line delay shifts once
// per pair, read at its tail in the same cycle, so no item waits on a memory port.
// Reset (rst, synchronous): registers return to width 256, height 256, unsigned;
// the tile restarts at row 0, column 0 and the pipeline empties. The line delay
// is not cleared; row 0 of every tile fills it before row 1 reads it.
`default_nettype none

module box_downsample_2x2_merge (
  input  wire logic                            clk,
  input  wire logic                            rst,
  bdm_in_if.sink                               items,
  bdm_out_if.source                            results,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [bdm_pkg::AddrBits-1:0]    paddr,
  input  wire logic [bdm_pkg::DataBits-1:0]    pwdata,
  output logic      [bdm_pkg::DataBits-1:0]    prdata,
  output logic                                 pready
);

  `include "box_downsample_2x2_merge_assert.svh"

  bdm_pkg::cfg_t                     cfg;

  logic [bdm_pkg::CoordBits-1:0]     col_count;
  logic [bdm_pkg::CoordBits-1:0]     row_count;
  logic [bdm_pkg::CoordBits-1:0]     col_next;
  logic [bdm_pkg::CoordBits-1:0]     row_next;
  logic [bdm_pkg::MeanBits-1:0]      left_sample;
  logic [bdm_pkg::MeanBits-1:0]      cur;
  bdm_pkg::pair_t                    pair;
  bdm_pkg::pair_t                    tail;
  logic [bdm_pkg::SumBits-1:0]       block_sum;
  logic                              accept;
  logic                              produce;
  logic                              last_col;
  logic                              last_row;
  logic                              col_in_range;
  logic [bdm_pkg::CoordBits-1:0]     half_w;
  logic [bdm_pkg::CoordBits-1:0]     half_h;
  logic [bdm_pkg::CoordBits-1:0]     ox;
  logic [bdm_pkg::CoordBits-1:0]     oy;

  logic                              mid_v;
  logic [bdm_pkg::SumBits-1:0]       mid_sum;
  logic [bdm_pkg::CoordBits-1:0]     mid_x;
  logic [bdm_pkg::CoordBits-1:0]     mid_y;
  logic                              mid_done;
  logic [bdm_pkg::SumBits-1:0]       round_sum;
  logic [bdm_pkg::MeanBits-1:0]      mean;

  logic                              out_v;
  logic                              out_en;
  logic                              mid_en;

  bdm_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign out_en      = !out_v || results.ready;
  assign mid_en      = !mid_v || out_en;
  assign items.ready = mid_en;
  assign accept      = items.valid && mid_en;
  assign produce     = col_count[0] && row_count[0];

  assign cur = {cfg.is_signed && items.sample[bdm_pkg::SampleBits-1],
                items.sample[bdm_pkg::SampleBits-1:0]};
  assign pair = {left_sample[bdm_pkg::MeanBits-1], left_sample}
                + {cur[bdm_pkg::MeanBits-1], cur};
  assign block_sum = {tail[bdm_pkg::PairBits-1], tail}
                     + {pair[bdm_pkg::PairBits-1], pair};

  // Each odd column pushes one pair; even rows store it, odd rows only keep
  // the delay aligned while the tail supplies the stored pair.
  bdm_line_chain u_line (
    .clk        (clk),
    .shift      (accept && col_count[0]),
    .inject_pos (cfg.inject_pos),
    .push_data  (pair),
    .tail_data  (tail)
  );

  assign last_col     = ({1'b0, col_count} == cfg.w_eff - bdm_pkg::DimBits'(1));
  assign last_row     = ({1'b0, row_count} == cfg.h_eff - bdm_pkg::DimBits'(1));
  assign col_in_range = ({1'b0, col_count} < cfg.w_eff);

  assign half_w = cfg.w_eff[bdm_pkg::DimBits-1:1];
  assign half_h = cfg.h_eff[bdm_pkg::DimBits-1:1];
  assign ox = ({bdm_pkg::CoordBits{items.quadrant[0]}} & half_w)
              + bdm_pkg::CoordBits'(col_count[bdm_pkg::CoordBits-1:1]);
  assign oy = ({bdm_pkg::CoordBits{items.quadrant[1]}} & half_h)
              + bdm_pkg::CoordBits'(row_count[bdm_pkg::CoordBits-1:1]);

  always_comb begin
    col_next = col_count;
    row_next = row_count;
    if (last_col) begin
      col_next = '0;
      row_next = last_row ? '0 : row_count + bdm_pkg::CoordBits'(1);
    end else begin
      col_next = col_count + bdm_pkg::CoordBits'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_count   <= '0;
      row_count   <= '0;
      left_sample <= '0;
    end else begin
      priority if (cfg.restart) begin
        col_count <= '0;
        row_count <= '0;
      end else if (accept) begin
        col_count <= col_next;
        row_count <= row_next;
      end else begin
        col_count <= col_count;
        row_count <= row_count;
      end
      if (accept) begin
        left_sample <= cur;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mid_v <= 1'b0;
    end else if (mid_en) begin
      mid_v <= accept && produce;
    end
  end

  always_ff @(posedge clk) begin
    if (mid_en && accept && produce) begin
      mid_sum  <= block_sum;
      mid_x    <= ox;
      mid_y    <= oy;
      mid_done <= last_col && last_row;
    end
  end

  // Half away from zero on a quarter: add 2 when positive, 1 when negative,
  // then floor by an arithmetic shift.
  assign round_sum = mid_sum + (mid_sum[bdm_pkg::SumBits-1] ? bdm_pkg::SumBits'(1)
                                                            : bdm_pkg::SumBits'(2));
  assign mean = round_sum[bdm_pkg::SumBits-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else if (out_en) begin
      out_v <= mid_v;
    end
  end

  always_ff @(posedge clk) begin
    if (out_en && mid_v) begin
      results.out_x     <= mid_x;
      results.out_y     <= mid_y;
      results.average   <= bdm_pkg::DataBits'($signed(mean));
      results.tile_done <= mid_done;
    end
  end

  assign results.valid = out_v;

  `BDM_ASSERT_NEXT(a_block_staged, clk, rst, accept && produce, mid_v)
  `BDM_ASSERT_NEXT(a_no_extra_result, clk, rst, accept && !produce, !mid_v)
  `BDM_ASSERT_NEXT(a_restart_origin, clk, rst, cfg.restart, col_count == '0 && row_count == '0)
  `BDM_ASSERT_NOW(a_col_in_tile, clk, rst, 1'b1, col_in_range)
  `BDM_ASSERT_NEXT(a_stall_keeps_mid, clk, rst, mid_v && !out_en, mid_v)

endmodule

`default_nettype wire

// ===== verif/tb_box_downsample_2x2_merge.sv =====
`timescale 1ns / 1ps

module tb_box_downsample_2x2_merge;

  // Address 12 decodes to no register; writes there must leave the tile alone.
  localparam logic [1:0] RegReserved = 2'd3;

  typedef struct packed {
    logic [bdm_pkg::QuadBits-1:0] quadrant;
    logic [bdm_pkg::DataBits-1:0] sample;
  } src_item_t;

  typedef struct packed {
    logic [bdm_pkg::CoordBits-1:0] out_x;
    logic [bdm_pkg::CoordBits-1:0] out_y;
    logic [bdm_pkg::DataBits-1:0]  average;
    logic                          tile_done;
  } avg_item_t;

  logic clk = 1'b0;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [bdm_pkg::AddrBits-1:0] paddr;
  logic [bdm_pkg::DataBits-1:0] pwdata;
  logic [bdm_pkg::DataBits-1:0] prdata;
  logic pready;

  bdm_in_if  items_if ();
  bdm_out_if results_if ();

  box_downsample_2x2_merge dut (
    .clk     (clk),
    .rst     (rst),
    .items   (items_if),
    .results (results_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  src_item_t sample_queue[$];
  avg_item_t expected_averages[$];
  int send_idle_pct;
  int recv_stall_pct;
  int mismatches;
  int items_taken;
  int averages_checked;
  int settings_used;

  // Shadow of the block: registers, line of pair sums and raster position.
  logic [bdm_pkg::DimBits-1:0] cfg_width;
  logic [bdm_pkg::DimBits-1:0] cfg_height;
  logic                        cfg_signed;
  longint                      line_sums[bdm_pkg::LineDepth];
  longint                      left_value;
  int unsigned                 src_col;
  int unsigned                 src_row;

  function automatic int unsigned even_clamp(int unsigned v, int unsigned hi);
    if (v < 2) v = 2;
    if (v > hi) v = hi;
    return v & ~32'd1;
  endfunction

  function automatic void fold_sample(src_item_t it);
    int unsigned w;
    int unsigned h;
    int unsigned ox;
    int unsigned oy;
    longint cur;
    longint pair;
    longint total;
    longint mean;
    avg_item_t r;
    w = even_clamp(cfg_width, bdm_pkg::MaxWidth);
    h = even_clamp(cfg_height, bdm_pkg::MaxHeight);
    cur = cfg_signed ? longint'($signed(it.sample)) : longint'(it.sample);
    if (src_col[0]) begin
      pair = left_value + cur;
      if (!src_row[0]) begin
        line_sums[(src_col >> 1) % bdm_pkg::LineDepth] = pair;
      end else begin
        total = line_sums[(src_col >> 1) % bdm_pkg::LineDepth] + pair;
        // Round half away from zero on the quarter.
        mean = (total >= 0) ? ((total + 2) >>> 2) : -((2 - total) >>> 2);
        ox = (it.quadrant[0] ? w / 2 : 0) + src_col / 2;
        oy = (it.quadrant[1] ? h / 2 : 0) + src_row / 2;
        r.out_x = ox[bdm_pkg::CoordBits-1:0];
        r.out_y = oy[bdm_pkg::CoordBits-1:0];
        r.average = mean[bdm_pkg::DataBits-1:0];
        r.tile_done = (src_row == h - 1) && (src_col == w - 1);
        expected_averages.push_back(r);
      end
    end
    left_value = cur;
    src_col++;
    if (src_col >= w) begin
      src_col = 0;
      src_row++;
      if (src_row >= h) src_row = 0;
    end
  endfunction

  task automatic report_mismatch(string what, logic [bdm_pkg::DataBits-1:0] got,
                                 logic [bdm_pkg::DataBits-1:0] want);
    $display("MISMATCH at %0t: %s got 0x%0h expected 0x%0h", $realtime, what, got, want);
    mismatches++;
  endtask

  // Sender: holds an item until it is taken, idles only between items.
  always @(posedge clk) begin : drive_items
    src_item_t next;
    if (rst) begin
      items_if.valid <= 1'b0;
    end else begin
      if (items_if.valid && items_if.ready) begin
        fold_sample(src_item_t'{items_if.quadrant, items_if.sample});
        items_taken++;
      end
      if (!items_if.valid || items_if.ready) begin
        if (sample_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          next = sample_queue.pop_front();
          items_if.valid <= 1'b1;
          items_if.quadrant <= next.quadrant;
          items_if.sample <= next.sample;
        end else begin
          items_if.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      results_if.ready <= 1'b0;
    end else begin
      results_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin : check_results
    avg_item_t want;
    if (!rst && results_if.valid && results_if.ready) begin
      if (expected_averages.size() == 0) begin
        report_mismatch("result with none expected, average", results_if.average, '0);
      end else begin
        want = expected_averages.pop_front();
        averages_checked++;
        if (results_if.out_x !== want.out_x)
          report_mismatch("out_x", bdm_pkg::DataBits'(results_if.out_x),
                          bdm_pkg::DataBits'(want.out_x));
        if (results_if.out_y !== want.out_y)
          report_mismatch("out_y", bdm_pkg::DataBits'(results_if.out_y),
                          bdm_pkg::DataBits'(want.out_y));
        if (results_if.average !== want.average)
          report_mismatch("average", results_if.average, want.average);
        if (results_if.tile_done !== want.tile_done)
          report_mismatch("tile_done", bdm_pkg::DataBits'(results_if.tile_done),
                          bdm_pkg::DataBits'(want.tile_done));
      end
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [bdm_pkg::DataBits-1:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      bdm_pkg::RegTileWidth:     cfg_width = value[bdm_pkg::DimBits-1:0];
      bdm_pkg::RegTileHeight:    cfg_height = value[bdm_pkg::DimBits-1:0];
      bdm_pkg::RegSignedSamples: cfg_signed = value[0];
      default:                   ;
    endcase
    if (idx != RegReserved) begin
      src_col = 0;
      src_row = 0;
    end
  endtask

  // Items that end in no result may still be in the pipe, hence the extra cycles.
  task automatic wait_drained();
    do @(posedge clk);
    while (sample_queue.size() != 0 || items_if.valid || expected_averages.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_tile(logic [bdm_pkg::DataBits-1:0] w, logic [bdm_pkg::DataBits-1:0] h,
                          logic [bdm_pkg::DataBits-1:0] sgn);
    wait_drained();
    write_reg(bdm_pkg::RegTileWidth, w);
    write_reg(bdm_pkg::RegTileHeight, h);
    write_reg(bdm_pkg::RegSignedSamples, sgn);
    settings_used++;
  endtask

  task automatic push_block(logic [1:0] quad, logic [31:0] a, logic [31:0] b,
                            logic [31:0] c, logic [31:0] d);
    sample_queue.push_back('{quad, a});
    sample_queue.push_back('{quad, b});
    sample_queue.push_back('{quad, c});
    sample_queue.push_back('{quad, d});
  endtask

  function automatic logic [bdm_pkg::DataBits-1:0] pick_sample();
    case ($urandom_range(7))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      2: return 32'h7FFF_FFFF;
      3: return 32'h8000_0000;
      4: return $urandom_range(7);
      5: return 32'hFFFF_FFF8 | $urandom_range(7);
      default: return $urandom;
    endcase
  endfunction

  task automatic run_phase(logic [bdm_pkg::DataBits-1:0] w, logic [bdm_pkg::DataBits-1:0] h,
                           logic [bdm_pkg::DataBits-1:0] sgn, int send_pct, int recv_pct,
                           int n);
    set_tile(w, h, sgn);
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
    repeat (n) sample_queue.push_back('{2'($urandom_range(3)), pick_sample()});
  endtask

  initial begin
    logic [bdm_pkg::DataBits-1:0] w_raw;
    logic [bdm_pkg::DataBits-1:0] h_raw;
    logic [bdm_pkg::DataBits-1:0] s_raw;
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    mismatches = 0;
    items_taken = 0;
    averages_checked = 0;
    settings_used = 0;
    cfg_width = bdm_pkg::WidthReset;
    cfg_height = bdm_pkg::HeightReset;
    cfg_signed = 1'b0;
    foreach (line_sums[i]) line_sums[i] = 0;
    left_value = 0;
    src_col = 0;
    src_row = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Smallest tile, so every block is a whole tile and ends it.
    set_tile(2, 2, 0);
    push_block(2'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_block(2'd0, 32'h0, 32'h0, 32'h0, 32'h0);
    push_block(2'd1, 32'h1, 32'h0, 32'h0, 32'h1);
    set_tile(2, 2, 1);
    push_block(2'd2, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'hFFFF_FFFF);
    push_block(2'd3, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    push_block(2'd0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    // A write to the unused address in mid-tile must not restart the tile.
    sample_queue.push_back('{2'd1, 32'hFFFF_FFFF});
    sample_queue.push_back('{2'd1, 32'h0});
    wait_drained();
    write_reg(RegReserved, 32'hFFFF_FFFF);
    sample_queue.push_back('{2'd2, 32'h0});
    sample_queue.push_back('{2'd2, 32'h0});

    run_phase(8, 6, 0, 0, 0, 150);
    // Width beyond range clamps to the maximum; a row and a half of that tile.
    run_phase(32'hFFFF_F7FF, 2, 1, 68, 0, bdm_pkg::MaxWidth + bdm_pkg::MaxWidth / 2);
    run_phase(0, 32'h0000_07FF, 0, 0, 68, 150);
    repeat (4) begin
      w_raw = $urandom;
      w_raw[bdm_pkg::DimBits-1:0] = bdm_pkg::DimBits'($urandom_range(40));
      h_raw = $urandom;
      h_raw[bdm_pkg::DimBits-1:0] = bdm_pkg::DimBits'($urandom_range(12));
      s_raw = $urandom;
      run_phase(w_raw, h_raw, s_raw, 30, 30, 60);
    end

    wait_drained();
    repeat (10) @(posedge clk);
    $display("Run covered %0d items and %0d averages over %0d tile settings,",
             items_taken, averages_checked, settings_used);
    $display("with and without idling on the item and result sides; %0d mismatches.",
             mismatches);
    if (mismatches == 0) begin
      $display("box_downsample_2x2_merge regression: pass");
    end else begin
      $display("box_downsample_2x2_merge regression: fail");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("Timed out with %0d averages still expected.", expected_averages.size());
    $display("box_downsample_2x2_merge regression: fail");
    $finish;
  end

endmodule
